[sv/pwmeds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmeds_pkg
// shared widths, constants and handshake structs for the pwm divider search
// ----------------------------------------------------------------------------
package pwmeds_pkg;

  localparam int CLK_W  = 32;            // source clock and request width
  localparam int FRAC_W = 4;             // divider fraction bits
  localparam int DVD_W  = CLK_W + FRAC_W; // dividend width of the serial divider
  localparam int DVS_W  = CLK_W;         // divisor width of the serial divider
  localparam int DIV_W  = 12;            // scaled divider field width
  localparam int WRAP_W = 16;            // wrap field width
  localparam int CNT_W  = $clog2(DVD_W);

  localparam int PERIOD_MAX_DEF  = 65535;
  localparam int DIVIDER_MAX_DEF = 4095;
  localparam int DIV_MIN         = 16;

  localparam logic [CLK_W-1:0] CLK_RESET = 32'd125000000;

  // launch word to the serial divider
  typedef struct packed {
    logic             go;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // result word from the serial divider
  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

[sv/pwm_exact_divider_search_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_exact_divider_search_unit
// exact pwm divider and wrap search over one shared serial divider
// ----------------------------------------------------------------------------
// sequence: a zero clock or request is answered without a division; else one
//   division on the shared serial divider for scaled clock / request,
//   one for the lower divider bound, then one per candidate, up to 4082 in all
// throughput: one word at a time, busy stays high for the whole search
// reset: synchronous active-low rst_n idles the sequencer, drops the strobe
//   and loads source_clock_hz with 125000000; the receiver cannot stall
// ----------------------------------------------------------------------------
module pwm_exact_divider_search_unit #(
  parameter int PERIOD_MAX  = pwmeds_pkg::PERIOD_MAX_DEF,
  parameter int DIVIDER_MAX = pwmeds_pkg::DIVIDER_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pwmeds_pkg::CLK_W-1:0]    cfg_source_clock_hz,
  // command input
  input  logic                            start,
  output logic                            busy,
  input  logic [pwmeds_pkg::CLK_W-1:0]    in_request_hz,
  // result strobe
  output logic                            out_valid,
  output logic                            out_found,
  output logic [pwmeds_pkg::DIV_W-1:0]    out_divider_q4,
  output logic [pwmeds_pkg::WRAP_W-1:0]   out_wrap
);

  localparam int DVD_W  = pwmeds_pkg::DVD_W;
  localparam int DVS_W  = pwmeds_pkg::DVS_W;
  localparam int DIV_W  = pwmeds_pkg::DIV_W;
  localparam int CAND_W = DVD_W + 1;

  // one-hot sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // waiting for a command
    ST_QUOT = 4'b0010,  // scaled clock / request
    ST_LOW  = 4'b0100,  // (product - 1) / PERIOD_MAX for the lower bound
    ST_SCAN = 4'b1000   // product / candidate divider
  } state_t;

  state_t                        state_r, state_nxt;
  logic [pwmeds_pkg::CLK_W-1:0]  clk_hz_r, clk_hz_nxt;
  logic [DVD_W-1:0]              product_r, product_nxt;
  logic [DIV_W-1:0]              cand_r, cand_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          found_r, found_nxt;
  logic [DIV_W-1:0]              div_out_r, div_out_nxt;
  logic [pwmeds_pkg::WRAP_W-1:0] wrap_r, wrap_nxt;

  // registered launch word for the divider
  pwmeds_pkg::div_req_t          div_req_r, div_req_nxt;
  pwmeds_pkg::div_rsp_t          div_rsp;

  logic [CAND_W-1:0]             low_bound;

  pwmeds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  // ceil(product / PERIOD_MAX) = floor((product - 1) / PERIOD_MAX) + 1, clamped below
  always_comb begin
    low_bound = {1'b0, div_rsp.quotient} + CAND_W'(1);
    if (low_bound < CAND_W'(pwmeds_pkg::DIV_MIN)) begin
      low_bound = CAND_W'(pwmeds_pkg::DIV_MIN);
    end
  end

  always_comb begin
    state_nxt            = state_r;
    clk_hz_nxt           = clk_hz_r;
    product_nxt          = product_r;
    cand_nxt             = cand_r;
    out_valid_nxt        = 1'b0;
    found_nxt            = found_r;
    div_out_nxt          = div_out_r;
    wrap_nxt             = wrap_r;
    div_req_nxt          = div_req_r;
    div_req_nxt.go       = 1'b0;

    if (cfg_valid) begin
      clk_hz_nxt = cfg_source_clock_hz;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (clk_hz_r == '0 || in_request_hz == '0) begin
            // nothing to search, fail at once
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b0;
            div_out_nxt   = '0;
            wrap_nxt      = '0;
          end else begin
            div_req_nxt.go       = 1'b1;
            div_req_nxt.dividend = {clk_hz_r, pwmeds_pkg::FRAC_W'(0)};
            div_req_nxt.divisor  = in_request_hz;
            state_nxt            = ST_QUOT;
          end
        end
      end
      ST_QUOT: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder != '0) begin
            // request does not divide the scaled clock
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b0;
            div_out_nxt   = '0;
            wrap_nxt      = '0;
            state_nxt     = ST_IDLE;
          end else begin
            // quotient is at least one here since the remainder is zero
            product_nxt          = div_rsp.quotient;
            div_req_nxt.go       = 1'b1;
            div_req_nxt.dividend = div_rsp.quotient - DVD_W'(1);
            div_req_nxt.divisor  = DVS_W'(PERIOD_MAX);
            state_nxt            = ST_LOW;
          end
        end
      end
      ST_LOW: begin
        if (div_rsp.done) begin
          if (low_bound > CAND_W'(DIVIDER_MAX)) begin
            // period would overflow for every divider
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b0;
            div_out_nxt   = '0;
            wrap_nxt      = '0;
            state_nxt     = ST_IDLE;
          end else begin
            cand_nxt             = low_bound[DIV_W-1:0];
            div_req_nxt.go       = 1'b1;
            div_req_nxt.dividend = product_r;
            div_req_nxt.divisor  = DVS_W'(low_bound[DIV_W-1:0]);
            state_nxt            = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0 && div_rsp.quotient != '0 &&
              div_rsp.quotient <= DVD_W'(PERIOD_MAX)) begin
            // exact hit, first one wins
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b1;
            div_out_nxt   = cand_r;
            wrap_nxt      = div_rsp.quotient[pwmeds_pkg::WRAP_W-1:0] -
                            pwmeds_pkg::WRAP_W'(1);
            state_nxt     = ST_IDLE;
          end else if (cand_r == DIV_W'(DIVIDER_MAX)) begin
            // range exhausted
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b0;
            div_out_nxt   = '0;
            wrap_nxt      = '0;
            state_nxt     = ST_IDLE;
          end else begin
            cand_nxt             = cand_r + DIV_W'(1);
            div_req_nxt.go       = 1'b1;
            div_req_nxt.dividend = product_r;
            div_req_nxt.divisor  = DVS_W'(cand_r + DIV_W'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      clk_hz_r     <= pwmeds_pkg::CLK_RESET;
      out_valid_r  <= 1'b0;
      div_req_r.go <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clk_hz_r     <= clk_hz_nxt;
      out_valid_r  <= out_valid_nxt;
      div_req_r.go <= div_req_nxt.go;
    end
    div_req_r.dividend <= div_req_nxt.dividend;
    div_req_r.divisor  <= div_req_nxt.divisor;
    product_r          <= product_nxt;
    cand_r             <= cand_nxt;
    found_r            <= found_nxt;
    div_out_r          <= div_out_nxt;
    wrap_r             <= wrap_nxt;
  end

  // config words must only be written while idle (the block does not enforce it), so always take them
  assign cfg_ready      = 1'b1;
  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_divider_q4 = div_out_r;
  assign out_wrap       = wrap_r;

endmodule

[sv/pwmeds_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmeds_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pwmeds_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pwmeds_pkg::div_req_t req,
  output pwmeds_pkg::div_rsp_t rsp
);

  logic [pwmeds_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [pwmeds_pkg::DVD_W-1:0] quo_r, quo_nxt;
  logic [pwmeds_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [pwmeds_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                         run_r, run_nxt;
  logic                         done_r, done_nxt;
  logic [pwmeds_pkg::DVS_W:0]   shifted;
  logic [pwmeds_pkg::DVS_W:0]   diff;
  logic                         ge;

  assign shifted = {rem_r, quo_r[pwmeds_pkg::DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.go) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[pwmeds_pkg::DVS_W-1:0] : shifted[pwmeds_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[pwmeds_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r + pwmeds_pkg::CNT_W'(1);
      if (cnt_r == pwmeds_pkg::CNT_W'(pwmeds_pkg::DVD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

[sv/pwmeds_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmeds_chk
// port-level checks for the pwm divider search unit
// ----------------------------------------------------------------------------
module pwmeds_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            out_found,
  input logic [pwmeds_pkg::DIV_W-1:0]    out_divider_q4,
  input logic [pwmeds_pkg::WRAP_W-1:0]   out_wrap
);

  // a failed search carries zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_divider_q4 == '0 && out_wrap == '0))
    else $error("failed result with nonzero fields");

  // a hit never uses a divider below one
  a_found_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |->
      (out_divider_q4 >= pwmeds_pkg::DIV_W'(pwmeds_pkg::DIV_MIN)))
    else $error("found divider below minimum");

  // an accepted command either starts a search or answers at once
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command dropped");

  // a result word only shows once the search is over
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

endmodule

bind pwm_exact_divider_search_unit pwmeds_chk u_pwmeds_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_found      (out_found),
  .out_divider_q4 (out_divider_q4),
  .out_wrap       (out_wrap)
);

[tb/pwm_exact_divider_search_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_exact_divider_search_unit_tb
// self-checking bench for the exact pwm divider and wrap search: a directed
// pass over the corner requests and clock settings, then random phases that
// mostly ask for requests dividing the scaled clock, each word predicted in
// the bench and compared field by field against the result strobe
// ----------------------------------------------------------------------------
module pwm_exact_divider_search_unit_tb;

  localparam int CLK_W   = pwmeds_pkg::CLK_W;
  localparam int FRAC_W  = pwmeds_pkg::FRAC_W;
  localparam int DIV_W   = pwmeds_pkg::DIV_W;
  localparam int WRAP_W  = pwmeds_pkg::WRAP_W;
  localparam int DIV_MIN = pwmeds_pkg::DIV_MIN;
  localparam logic [CLK_W-1:0] CLK_RESET = pwmeds_pkg::CLK_RESET;

  // search limits of the default build
  localparam longint unsigned PERIOD_LIMIT  = pwmeds_pkg::PERIOD_MAX_DEF;
  localparam longint unsigned DIVIDER_LIMIT = pwmeds_pkg::DIVIDER_MAX_DEF;

  // a word scanning more candidates than this counts as slow: one full scan
  // walks all 4080 candidate dividers, so only a couple of random ones are allowed
  localparam int unsigned FAST_SCAN  = 100;
  localparam int unsigned SLOW_WORDS = 2;

  // cycles without any handshake before the run is declared hung: several
  // times one full candidate scan
  localparam int unsigned HANG_LIMIT = 640000;
  localparam int unsigned TAIL_CYCLES = 64;

  // clock settings that give the widest results
  localparam logic [CLK_W-1:0] CLK_WRAP_MAX = 32'd65535;      // div 16, period 65535
  localparam logic [CLK_W-1:0] CLK_BOTH_MAX = 32'd268365825;  // 4095 * 65535

  typedef enum logic [1:0] {
    STIM_REQUEST,  // frequency request word on the command port
    STIM_CLOCK,    // source clock write, only once the block is idle
    STIM_DRAIN     // hold off until every result has come back
  } stim_kind_t;

  typedef struct {
    stim_kind_t       kind;
    logic [CLK_W-1:0] value;
  } stim_word_t;

  typedef struct packed {
    logic              found;
    logic [DIV_W-1:0]  divider_q4;
    logic [WRAP_W-1:0] wrap;
  } pwm_setting_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CLK_W-1:0]  cfg_source_clock_hz = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [CLK_W-1:0]  in_request_hz = '0;
  logic              out_valid;
  logic              out_found;
  logic [DIV_W-1:0]  out_divider_q4;
  logic [WRAP_W-1:0] out_wrap;

  // stimulus waiting for the driver, and settings waiting for the strobe
  stim_word_t   pending_words[$];
  pwm_setting_t expected_settings[$];

  // bench copy of the source clock register
  logic [CLK_W-1:0] model_clock_hz;
  int unsigned      slow_left = SLOW_WORDS;

  // driver state, owned by the falling-edge process
  stim_word_t  cur;
  bit          cur_live = 1'b0;
  bit          gapless = 1'b0;
  int unsigned gap_left = 0;
  logic        nxt_start;
  logic        nxt_cfg_valid;

  // handshakes seen at the last rising edge, read by the driver
  logic cmd_fire = 1'b0;
  logic cfg_fire = 1'b0;

  // monitor state
  pwm_setting_t want;
  int unsigned  scan_len;
  int unsigned  idle_cycles = 0;
  int unsigned  fault_count = 0;

  pwm_exact_divider_search_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_source_clock_hz (cfg_source_clock_hz),
    .start               (start),
    .busy                (busy),
    .in_request_hz       (in_request_hz),
    .out_valid           (out_valid),
    .out_found           (out_found),
    .out_divider_q4      (out_divider_q4),
    .out_wrap            (out_wrap)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected divider and wrap for one request; trials returns how many
  // candidate dividers the search walks, used to keep the run short
  function automatic pwm_setting_t search_divider(input logic [CLK_W-1:0] clock_hz,
                                                  input logic [CLK_W-1:0] request_hz,
                                                  output int unsigned trials);
    logic [63:0]  scaled;
    logic [63:0]  product;
    logic [63:0]  first;
    logic [63:0]  period;
    logic [63:0]  d;
    pwm_setting_t res;
    res = '0;
    trials = 0;
    // zero clock or zero request never finds a setting
    if (clock_hz == '0 || request_hz == '0) return res;
    scaled = 64'(clock_hz) << FRAC_W;
    // the request must divide the clock scaled by the fraction bits
    if (scaled % 64'(request_hz) != 0) return res;
    product = scaled / 64'(request_hz);
    // lowest divider that keeps the period within range, never below 1.0
    first = (product + PERIOD_LIMIT - 1) / PERIOD_LIMIT;
    if (first < DIV_MIN) first = DIV_MIN;
    for (d = first; d <= DIVIDER_LIMIT; d++) begin
      trials++;
      if (product % d == 0) begin
        period = product / d;
        if (period >= 1 && period <= PERIOD_LIMIT) begin
          res.found      = 1'b1;
          res.divider_q4 = d[DIV_W-1:0];
          res.wrap       = period[WRAP_W-1:0] - 1'b1;
          return res;
        end
      end
    end
    // no exact divider in range
    return res;
  endfunction

  task automatic plan_word(input stim_kind_t kind, input logic [CLK_W-1:0] value);
    stim_word_t w;
    w.kind  = kind;
    w.value = value;
    pending_words.push_back(w);
  endtask

  // one clock setting, then mostly requests that divide the scaled clock
  // (the scaled clock with random small factors divided out) and some plain
  // noise; slow searches are drawn again unless the slow budget allows one
  task automatic plan_random_phase(input logic [CLK_W-1:0] clock_hz,
                                   input int unsigned count);
    logic [CLK_W-1:0] req;
    logic [63:0]      left;
    longint unsigned  p;
    int unsigned      tries;
    int unsigned      trials;
    plan_word(STIM_CLOCK, clock_hz);
    for (int unsigned n = 0; n < count; n++) begin
      tries = 0;
      forever begin
        tries++;
        if (tries > 40) begin
          req = '0;
        end else if ($urandom_range(3, 0) != 0) begin
          left = 64'(clock_hz) << FRAC_W;
          repeat ($urandom_range(40, 0)) begin
            case ($urandom_range(8, 0))
              0: p = 2;
              1: p = 3;
              2: p = 5;
              3: p = 7;
              4: p = 11;
              5: p = 13;
              6: p = 17;
              7: p = 257;
              default: p = 65537;
            endcase
            if (left != 0 && left % p == 0) left = left / p;
          end
          if (left == 0 || left[63:32] != '0) req = $urandom;
          else req = left[CLK_W-1:0];
        end else if ($urandom_range(1, 0) != 0) begin
          req = $urandom;
        end else begin
          req = $urandom_range(4096, 1);
        end
        void'(search_divider(clock_hz, req, trials));
        if (trials <= FAST_SCAN) break;
        if (slow_left != 0) begin
          slow_left--;
          break;
        end
      end
      plan_word(STIM_REQUEST, req);
      // hold the sender once mid-phase until the block has drained
      if (n == count / 2) plan_word(STIM_DRAIN, '0);
    end
  endtask

  // driver: inputs change on the falling edge, one word at a time, with
  // random gaps (mostly short, some long, some stretches with none)
  always @(negedge clk) begin
    nxt_start     = 1'b0;
    nxt_cfg_valid = 1'b0;
    if (rst_n) begin
      // retire the word taken at the last rising edge and pick a gap
      if (cur_live && (cmd_fire || cfg_fire)) begin
        cur_live = 1'b0;
        if ($urandom_range(7, 0) == 0) gapless = !gapless;
        if (gapless) gap_left = 0;
        else if ($urandom_range(9, 0) == 0) gap_left = $urandom_range(80, 10);
        else gap_left = $urandom_range(3, 0);
      end
      if (!cur_live) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          cur      = pending_words.pop_front();
          cur_live = 1'b1;
        end
      end
      if (cur_live) begin
        case (cur.kind)
          STIM_REQUEST: begin
            nxt_start = 1'b1;
          end
          STIM_CLOCK: begin
            // register writes only once every result is back and busy is low
            nxt_cfg_valid = (expected_settings.size() == 0) && !busy;
          end
          default: begin
            if (expected_settings.size() == 0 && !busy) cur_live = 1'b0;
          end
        endcase
      end
    end
    start     <= nxt_start;
    cfg_valid <= nxt_cfg_valid;
    if (nxt_start) in_request_hz <= cur.value;
    if (nxt_cfg_valid) cfg_source_clock_hz <= cur.value;
  end

  // monitor: handshakes and results are sampled on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_fire       <= 1'b0;
      cfg_fire       <= 1'b0;
      model_clock_hz = CLK_RESET;
      idle_cycles    = 0;
    end else begin
      cmd_fire <= start && !busy;
      cfg_fire <= cfg_valid && cfg_ready;

      // result word: compare with the oldest setting still owed
      if (out_valid) begin
        if (expected_settings.size() == 0) begin
          $error("result word with nothing expected: found %0d divider_q4 %0d wrap %0d",
                 out_found, out_divider_q4, out_wrap);
          fault_count++;
        end else begin
          want = expected_settings.pop_front();
          if (out_found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_found);
            fault_count++;
          end
          if (out_divider_q4 !== want.divider_q4) begin
            $error("divider_q4: expected %0d, actual %0d",
                   want.divider_q4, out_divider_q4);
            fault_count++;
          end
          if (out_wrap !== want.wrap) begin
            $error("wrap: expected %0d, actual %0d", want.wrap, out_wrap);
            fault_count++;
          end
        end
      end

      // register write lands before any later request is predicted
      if (cfg_valid && cfg_ready) model_clock_hz = cfg_source_clock_hz;

      // accepted request: predict its setting with the clock now in force
      if (start && !busy)
        expected_settings.push_back(search_divider(model_clock_hz, in_request_hz, scan_len));

      // watchdog on cycles with no handshake at all
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("pwm_exact_divider_search_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    // reset clock value: zero request, a request that does not divide,
    // a product past the largest divider times the longest period, exact
    // hits, and a product of one that walks every candidate without a hit
    plan_word(STIM_REQUEST, 32'd0);
    plan_word(STIM_REQUEST, 32'hFFFF_FFFF);
    plan_word(STIM_REQUEST, 32'd3);
    plan_word(STIM_REQUEST, 32'd1);
    plan_word(STIM_REQUEST, 32'd1000);
    plan_word(STIM_REQUEST, 32'd20000);
    plan_word(STIM_REQUEST, 32'd500);
    plan_word(STIM_REQUEST, 32'd2000000000);

    // zero clock fails everything
    plan_word(STIM_CLOCK, 32'd0);
    plan_word(STIM_REQUEST, 32'd1000);
    plan_word(STIM_REQUEST, 32'd0);

    // all-ones clock
    plan_word(STIM_CLOCK, 32'hFFFF_FFFF);
    plan_word(STIM_REQUEST, 32'hFFFF_FFFF);
    plan_word(STIM_REQUEST, 32'd1);
    plan_word(STIM_REQUEST, 32'h8000_0000);

    // smallest nonzero clock
    plan_word(STIM_CLOCK, 32'd1);
    plan_word(STIM_REQUEST, 32'd1);
    plan_word(STIM_REQUEST, 32'd3);

    // widest wrap, then widest divider together with widest wrap
    plan_word(STIM_CLOCK, CLK_WRAP_MAX);
    plan_word(STIM_REQUEST, 32'd1);
    plan_word(STIM_REQUEST, 32'd15);
    plan_word(STIM_CLOCK, CLK_BOTH_MAX);
    plan_word(STIM_REQUEST, 32'd16);
    plan_word(STIM_REQUEST, 32'd1);

    // random phases over several clock settings
    plan_random_phase(CLK_RESET, 18);
    plan_random_phase(32'd48000000, 14);
    plan_random_phase(32'd120000000, 14);
    plan_random_phase(32'hFFFF_FFFF, 12);
    plan_random_phase($urandom, 12);
    plan_random_phase($urandom_range(1000000, 1), 12);
    plan_random_phase(CLK_BOTH_MAX, 10);
    plan_random_phase(32'd0, 6);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for the queue to empty and every result to come back
    do @(posedge clk);
    while (pending_words.size() != 0 || cur_live || expected_settings.size() != 0 || busy);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0 && expected_settings.size() == 0) begin
      $display("pwm_exact_divider_search_unit_tb: PASS");
    end else begin
      $display("pwm_exact_divider_search_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pwmeds_pkg.sv
sv/pwmeds_div.sv
sv/pwm_exact_divider_search_unit.sv
sv/pwmeds_chk.sv
tb/pwm_exact_divider_search_unit_tb.sv
